// ===== rtl/cpup_pkg.sv =====
// ----------------------------------------------------------------------------
// cpup_pkg
// Shared types, constants and helpers of the color pointer update parser.
// ----------------------------------------------------------------------------
package cpup_pkg;

  localparam int unsigned MaxPointerSide = 96;
  localparam int unsigned HdrBytes       = 14;
  localparam int unsigned NumHdrFields   = 7;
  localparam int unsigned ResDepth       = 4;
  localparam int unsigned ResPtrW        = $clog2(ResDepth);
  localparam int unsigned ScanW          = 12;  // even-padded scanline bytes
  localparam int unsigned SideW          = 7;
  localparam int unsigned ProdW          = ScanW + SideW;

  // header field slots
  localparam int unsigned HfCache = 0;
  localparam int unsigned HfX     = 1;
  localparam int unsigned HfY     = 2;
  localparam int unsigned HfW     = 3;
  localparam int unsigned HfH     = 4;
  localparam int unsigned HfAnd   = 5;
  localparam int unsigned HfXor   = 6;

  typedef enum logic [2:0] {
    KIND_HDR  = 3'd0,
    KIND_XOR  = 3'd1,
    KIND_AND  = 3'd2,
    KIND_DONE = 3'd3,
    KIND_FAIL = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    FAIL_SHORT    = 3'd0,
    FAIL_SIZE     = 3'd1,
    FAIL_XOR_LEN  = 3'd2,
    FAIL_AND_LEN  = 3'd3,
    FAIL_TRUNC    = 3'd4
  } fail_e;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_CK_SIZE,
    PH_CK_XOR1,
    PH_CK_XOR2,
    PH_CK_AND,
    PH_XOR,
    PH_AND,
    PH_PAD,
    PH_DRAIN
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [15:0]       cache_slot;
    logic [SideW-1:0]  hot_x;
    logic [SideW-1:0]  hot_y;
    logic [SideW-1:0]  width;
    logic [SideW-1:0]  height;
    logic [7:0]        mask_byte;
    logic [15:0]       mask_offset;
    fail_e             fail_code;
    logic              final_res;
  } res_t;

  typedef struct packed {
    logic a;
    logic b;  // second beat of the same cycle, only together with a
  } push_t;

  // bits rounded up to bytes, then up to an even byte count
  function automatic logic [ScanW-1:0] scan_even(input logic [15:0] bits);
    logic [16:0] sum;
    logic [13:0] bytes;
    logic [13:0] even;
    sum   = {1'b0, bits} + 17'd7;
    bytes = sum[16:3];
    even  = bytes + {13'd0, bytes[0]};
    return even[ScanW-1:0];
  endfunction

  function automatic res_t res_blank(input kind_e kind);
    res_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic res_t res_fail(input fail_e code);
    res_t r;
    r           = res_blank(KIND_FAIL);
    r.fail_code = code;
    r.final_res = 1'b1;
    return r;
  endfunction

  function automatic res_t res_done();
    res_t r;
    r           = res_blank(KIND_DONE);
    r.final_res = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/cpup_res_fifo.sv =====
// ----------------------------------------------------------------------------
// cpup_res_fifo
// Result queue: takes up to two beats a cycle, hands out one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
module cpup_res_fifo
  import cpup_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  res_t  res_a_i,
  input  res_t  res_b_i,
  output logic  room2_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  out_res_o
);

  res_t                 mem [ResDepth];
  logic [ResPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ResPtrW:0]     count_q, count_d;
  logic                 pop;
  logic [ResPtrW:0]     n_push;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign room2_o     = (count_q <= (ResPtrW + 1)'(ResDepth - 2));
  assign out_res_o   = mem[rd_ptr_q];

  always_comb begin
    n_push   = (ResPtrW + 1)'(push_i.a) + (ResPtrW + 1)'(push_i.b);
    wr_ptr_d = wr_ptr_q + n_push[ResPtrW-1:0];
    rd_ptr_d = rd_ptr_q + ResPtrW'(pop);
    count_d  = count_q + n_push - (ResPtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.a) begin
      mem[wr_ptr_q] <= res_a_i;
    end
    if (push_i.b) begin
      mem[wr_ptr_q + ResPtrW'(1)] <= res_b_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (ResPtrW + 1)'(ResDepth))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.b |-> push_i.a)
    else $error("second beat pushed without first");

  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.b |-> (count_q <= (ResPtrW + 1)'(ResDepth - 2)))
    else $error("two beats pushed without room");

endmodule

// ===== rtl/color_pointer_update_parser.sv =====
// ----------------------------------------------------------------------------
// color_pointer_update_parser
// Parses a color pointer update byte stream: header, size checks, mask bytes.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  in      | in_valid_i, in_stall_o, in_byte_i,              | in
//          | end_of_message_i, xor_bpp_i                     |
//  out     | out_valid_o, out_stall_i, kind_o, cache_slot_o, | out
//          | hot_x_o, hot_y_o, pointer_width_o,              |
//          | pointer_height_o, mask_byte_o, mask_offset_o,   |
//          | fail_code_o, final_result_o                     |
//
// header, mask and pad bytes are taken one per cycle while the input is not stalled.
// after the 14th header byte the input stalls through the check states size,
// xor1, xor2 and and (up to the first failing check), while one shared
// 12x7 multiplier works out the xor and and lengths.
// results leave through a 4-deep queue, one beat per cycle unless out_stall_i
// holds it; the input stalls while the queue holds more than two beats.
// reset returns the parser to the start of a header with an empty queue.
module color_pointer_update_parser
  import cpup_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_message_i,
  input  logic [7:0]  xor_bpp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] cache_slot_o,
  output logic [6:0]  hot_x_o,
  output logic [6:0]  hot_y_o,
  output logic [6:0]  pointer_width_o,
  output logic [6:0]  pointer_height_o,
  output logic [7:0]  mask_byte_o,
  output logic [15:0] mask_offset_o,
  output logic [2:0]  fail_code_o,
  output logic        final_result_o
);

  phase_e              phase_q, phase_d;
  logic [3:0]          hdr_cnt_q, hdr_cnt_d;
  logic [15:0]         data_cnt_q, data_cnt_d;
  logic [7:0]          bpp_q, bpp_d;
  logic                eom_q, eom_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [15:0]         fields_q [NumHdrFields];

  logic                acc;
  logic                checking;
  logic                room2;
  logic                hdr_last;
  logic [2:0]          fld_idx;
  logic [15:0]         w16, h16, xl16, al16;
  logic [SideW-1:0]    w7, h7;
  logic                size_bad, xor_bad, and_bad;
  phase_e              first_phase;
  logic                is_xor;
  logic [15:0]         cur_len;
  logic [16:0]         cnt_inc;
  logic                data_end;
  phase_e              data_next;
  logic [ScanW-1:0]    mul_a;
  logic [SideW-1:0]    mul_b;
  push_t               push;
  res_t                res_a, res_b, hdr_res, out_res;

  // ---------------------------------------------------------------- decode
  assign checking = (phase_q == PH_CK_SIZE) || (phase_q == PH_CK_XOR1) ||
                    (phase_q == PH_CK_XOR2) || (phase_q == PH_CK_AND);
  assign in_stall_o = checking || !room2;
  assign acc        = in_valid_i && !in_stall_o;
  assign hdr_last   = (hdr_cnt_q == 4'(HdrBytes - 1));
  assign fld_idx    = hdr_cnt_q[3:1];

  assign w16  = fields_q[HfW];
  assign h16  = fields_q[HfH];
  assign xl16 = fields_q[HfXor];
  assign al16 = fields_q[HfAnd];
  assign w7   = w16[SideW-1:0];
  assign h7   = h16[SideW-1:0];

  assign size_bad = (w16 > 16'(MaxPointerSide)) || (h16 > 16'(MaxPointerSide));
  assign xor_bad  = (xl16 != '0) && ({{(ProdW - 16){1'b0}}, xl16} != prod_q);
  assign and_bad  = (al16 != '0) && ({{(ProdW - 16){1'b0}}, al16} != prod_q);

  assign first_phase = (xl16 != '0) ? PH_XOR : ((al16 != '0) ? PH_AND : PH_PAD);

  assign is_xor    = (phase_q == PH_XOR);
  assign cur_len   = is_xor ? xl16 : al16;
  assign cnt_inc   = {1'b0, data_cnt_q} + 17'd1;
  assign data_end  = (cnt_inc >= {1'b0, cur_len});
  assign data_next = (is_xor && (al16 != '0)) ? PH_AND : PH_PAD;

  // ------------------------------------------------------ shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (phase_q)
      PH_CK_SIZE: begin
        mul_a = {{(ScanW - 8){1'b0}}, bpp_q};
        mul_b = w7;
      end
      PH_CK_XOR1: begin
        mul_a = scan_even(prod_q[15:0]);
        mul_b = h7;
      end
      PH_CK_XOR2: begin
        mul_a = scan_even({{(16 - SideW){1'b0}}, w7});
        mul_b = h7;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = {{SideW{1'b0}}, mul_a} * {{ScanW{1'b0}}, mul_b};
  end

  // ------------------------------------------------------------ next state
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    data_cnt_d = data_cnt_q;
    bpp_d      = bpp_q;
    eom_d      = eom_q;
    case (phase_q)
      PH_HEADER: begin
        if (acc) begin
          if (hdr_cnt_q == '0) begin
            bpp_d = xor_bpp_i;
          end
          if (hdr_last) begin
            hdr_cnt_d = '0;
            eom_d     = end_of_message_i;
            phase_d   = PH_CK_SIZE;
          end else if (end_of_message_i) begin
            hdr_cnt_d = '0;
          end else begin
            hdr_cnt_d = hdr_cnt_q + 4'd1;
          end
        end
      end
      PH_CK_SIZE: begin
        if (size_bad) begin
          phase_d = eom_q ? PH_HEADER : PH_DRAIN;
        end else begin
          phase_d = PH_CK_XOR1;
        end
      end
      PH_CK_XOR1: begin
        phase_d = PH_CK_XOR2;
      end
      PH_CK_XOR2: begin
        if (xor_bad) begin
          phase_d = eom_q ? PH_HEADER : PH_DRAIN;
        end else begin
          phase_d = PH_CK_AND;
        end
      end
      PH_CK_AND: begin
        if (and_bad) begin
          phase_d = eom_q ? PH_HEADER : PH_DRAIN;
        end else begin
          data_cnt_d = '0;
          phase_d    = eom_q ? PH_HEADER : first_phase;
        end
      end
      PH_XOR, PH_AND: begin
        if (acc) begin
          data_cnt_d = data_end ? '0 : cnt_inc[15:0];
          if (end_of_message_i) begin
            phase_d = PH_HEADER;
          end else if (data_end) begin
            phase_d = data_next;
          end
        end
      end
      PH_PAD, PH_DRAIN: begin
        if (acc && end_of_message_i) begin
          phase_d = PH_HEADER;
        end
      end
      default: begin
        phase_d   = PH_HEADER;
        hdr_cnt_d = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- results
  always_comb begin
    hdr_res            = res_blank(KIND_HDR);
    hdr_res.cache_slot = fields_q[HfCache];
    hdr_res.hot_x      = (fields_q[HfX] >= w16) ? '0 : fields_q[HfX][SideW-1:0];
    hdr_res.hot_y      = (fields_q[HfY] >= h16) ? '0 : fields_q[HfY][SideW-1:0];
    hdr_res.width      = w7;
    hdr_res.height     = h7;
  end

  always_comb begin
    push  = '0;
    res_a = res_blank(KIND_HDR);
    res_b = res_blank(KIND_HDR);
    case (phase_q)
      PH_HEADER: begin
        if (acc && !hdr_last && end_of_message_i) begin
          push.a = 1'b1;
          res_a  = res_fail(FAIL_SHORT);
        end
      end
      PH_CK_SIZE: begin
        if (size_bad) begin
          push.a = 1'b1;
          res_a  = res_fail(FAIL_SIZE);
        end
      end
      PH_CK_XOR2: begin
        if (xor_bad) begin
          push.a = 1'b1;
          res_a  = res_fail(FAIL_XOR_LEN);
        end
      end
      PH_CK_AND: begin
        push.a = 1'b1;
        if (and_bad) begin
          res_a = res_fail(FAIL_AND_LEN);
        end else begin
          res_a  = hdr_res;
          push.b = eom_q;
          res_b  = (first_phase == PH_PAD) ? res_done() : res_fail(FAIL_TRUNC);
        end
      end
      PH_XOR, PH_AND: begin
        if (acc) begin
          push.a            = 1'b1;
          res_a             = res_blank(is_xor ? KIND_XOR : KIND_AND);
          res_a.mask_byte   = in_byte_i;
          res_a.mask_offset = data_cnt_q;
          push.b            = end_of_message_i;
          // message may end right on the last mask byte
          res_b = (data_end && (data_next == PH_PAD)) ? res_done()
                                                      : res_fail(FAIL_TRUNC);
        end
      end
      PH_PAD: begin
        if (acc && end_of_message_i) begin
          push.a = 1'b1;
          res_a  = res_done();
        end
      end
      default: begin
        push = '0;
      end
    endcase
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= '0;
      data_cnt_q <= '0;
      eom_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      data_cnt_q <= data_cnt_d;
      eom_q      <= eom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bpp_q  <= bpp_d;
    prod_q <= prod_d;
    if (acc && (phase_q == PH_HEADER)) begin
      if (hdr_cnt_q[0]) begin
        fields_q[fld_idx][15:8] <= in_byte_i;
      end else begin
        fields_q[fld_idx] <= {8'h00, in_byte_i};
      end
    end
  end

  cpup_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign kind_o           = out_res.kind;
  assign cache_slot_o     = out_res.cache_slot;
  assign hot_x_o          = out_res.hot_x;
  assign hot_y_o          = out_res.hot_y;
  assign pointer_width_o  = out_res.width;
  assign pointer_height_o = out_res.height;
  assign mask_byte_o      = out_res.mask_byte;
  assign mask_offset_o    = out_res.mask_offset;
  assign fail_code_o      = out_res.fail_code;
  assign final_result_o   = out_res.final_res;

  a_check_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    checking |-> in_stall_o)
    else $error("input taken during header checks");

  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_XOR) || (phase_q == PH_AND)) |-> (data_cnt_q < cur_len))
    else $error("mask offset past mask length");

  a_hdr_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (phase_q == PH_HEADER) && hdr_last) |=> (phase_q == PH_CK_SIZE))
    else $error("full header did not start checks");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Sends color pointer update messages into the parser byte by byte. A short
// directed list comes first, then random messages: mostly well-formed, plus
// broken ones. Each result beat is checked against a local parser model,
// under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpup_pkg::*;

  localparam int unsigned RandItems   = 1650;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam longint unsigned CycleLimit = 400000;

  // idling per phase of the random part, percent of cycles
  localparam int unsigned SendIdle [4] = '{0, 86, 0, 9};
  localparam int unsigned RecvStall [4] = '{0, 0, 86, 9};
  localparam logic [7:0] BppSet [7] = '{1, 2, 4, 8, 16, 24, 32};

  typedef struct {
    logic [7:0] b;
    logic       eom;
    logic [7:0] bpp;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        end_of_message_i = 1'b0;
  logic [7:0]  xor_bpp_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [15:0] cache_slot_o;
  logic [6:0]  hot_x_o;
  logic [6:0]  hot_y_o;
  logic [6:0]  pointer_width_o;
  logic [6:0]  pointer_height_o;
  logic [7:0]  mask_byte_o;
  logic [15:0] mask_offset_o;
  logic [2:0]  fail_code_o;
  logic        final_result_o;

  stim_row_t   msg [$];
  stim_row_t   cur_row;
  res_t        pending_beats [$];
  res_t        byte_beats [$];
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off = 1'b0;
  bit          pressure_go = 1'b0;
  longint unsigned cycle_cnt = 0;

  // parser model state
  phase_e      pphase = PH_HEADER;
  int unsigned hdr_cnt = 0;
  logic [15:0] hdr_f [NumHdrFields];
  logic [7:0]  bpp_latched = '0;
  logic [15:0] mask_pos = '0;

  color_pointer_update_parser uut (.*);

  always #5ns clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the result queue fills and the input stalls
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned even_scan(input int unsigned bits);
    int unsigned nbytes;
    nbytes = (bits + 7) / 8;
    return nbytes + (nbytes % 2);
  endfunction

  function automatic res_t fail_beat(input fail_e code);
    res_t r;
    r           = '0;
    r.kind      = KIND_FAIL;
    r.fail_code = code;
    r.final_res = 1'b1;
    return r;
  endfunction

  function automatic void push_fail(input fail_e code, input logic eom);
    byte_beats.push_back(fail_beat(code));
    hdr_cnt = 0;
    pphase  = eom ? PH_HEADER : PH_DRAIN;
  endfunction

  // end of message inside or right after the masks
  function automatic void close_msg(input logic eom);
    res_t r;
    if (!eom) return;
    if (pphase == PH_PAD) begin
      r           = '0;
      r.kind      = KIND_DONE;
      r.final_res = 1'b1;
      byte_beats.push_back(r);
      hdr_cnt = 0;
      pphase  = PH_HEADER;
    end else begin
      push_fail(FAIL_TRUNC, 1'b1);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eom,
                                     input logic [7:0] bpp);
    int unsigned idx, w, h, xl, al;
    logic [15:0] len;
    res_t r;
    byte_beats.delete();
    case (pphase)
      PH_HEADER: begin
        if (hdr_cnt == 0) bpp_latched = bpp;
        idx = hdr_cnt / 2;
        if (hdr_cnt % 2 == 1) hdr_f[idx] = {b, hdr_f[idx][7:0]};
        else hdr_f[idx] = {8'h00, b};
        hdr_cnt++;
        if (hdr_cnt < HdrBytes) begin
          if (eom) push_fail(FAIL_SHORT, 1'b1);
        end else begin
          hdr_cnt = 0;
          w  = 32'(hdr_f[HfW]);
          h  = 32'(hdr_f[HfH]);
          xl = 32'(hdr_f[HfXor]);
          al = 32'(hdr_f[HfAnd]);
          if (w > MaxPointerSide || h > MaxPointerSide) begin
            push_fail(FAIL_SIZE, eom);
          end else if (xl != 0 && even_scan(32'(bpp_latched) * w) * h != xl) begin
            push_fail(FAIL_XOR_LEN, eom);
          end else if (al != 0 && even_scan(w) * h != al) begin
            push_fail(FAIL_AND_LEN, eom);
          end else begin
            r            = '0;
            r.kind       = KIND_HDR;
            r.cache_slot = hdr_f[HfCache];
            r.hot_x      = (32'(hdr_f[HfX]) >= w) ? 7'd0 : hdr_f[HfX][6:0];
            r.hot_y      = (32'(hdr_f[HfY]) >= h) ? 7'd0 : hdr_f[HfY][6:0];
            r.width      = w[6:0];
            r.height     = h[6:0];
            byte_beats.push_back(r);
            mask_pos = '0;
            pphase   = (xl != 0) ? PH_XOR : ((al != 0) ? PH_AND : PH_PAD);
            close_msg(eom);
          end
        end
      end
      PH_XOR, PH_AND: begin
        r             = '0;
        r.kind        = (pphase == PH_XOR) ? KIND_XOR : KIND_AND;
        r.mask_byte   = b;
        r.mask_offset = mask_pos;
        byte_beats.push_back(r);
        len      = (pphase == PH_XOR) ? hdr_f[HfXor] : hdr_f[HfAnd];
        mask_pos = mask_pos + 16'd1;
        if (mask_pos >= len) begin
          mask_pos = '0;
          pphase   = (pphase == PH_XOR && hdr_f[HfAnd] != 0) ? PH_AND : PH_PAD;
        end
        close_msg(eom);
      end
      PH_PAD: close_msg(eom);
      default: begin
        // drain after a failure, silent up to end of message
        if (eom) begin
          pphase  = PH_HEADER;
          hdr_cnt = 0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    if (mismatch_cnt < 100)
      $display("%0t ns: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  task automatic check_beat(input res_t want, input res_t got);
    if (got.kind !== want.kind)
      report_mismatch("kind", 16'(want.kind), 16'(got.kind));
    if (got.cache_slot !== want.cache_slot)
      report_mismatch("cache_slot", want.cache_slot, got.cache_slot);
    if (got.hot_x !== want.hot_x)
      report_mismatch("hot_x", 16'(want.hot_x), 16'(got.hot_x));
    if (got.hot_y !== want.hot_y)
      report_mismatch("hot_y", 16'(want.hot_y), 16'(got.hot_y));
    if (got.width !== want.width)
      report_mismatch("pointer_width", 16'(want.width), 16'(got.width));
    if (got.height !== want.height)
      report_mismatch("pointer_height", 16'(want.height), 16'(got.height));
    if (got.mask_byte !== want.mask_byte)
      report_mismatch("mask_byte", 16'(want.mask_byte), 16'(got.mask_byte));
    if (got.mask_offset !== want.mask_offset)
      report_mismatch("mask_offset", want.mask_offset, got.mask_offset);
    if (got.fail_code !== want.fail_code)
      report_mismatch("fail_code", 16'(want.fail_code), 16'(got.fail_code));
    if (got.final_res !== want.final_res)
      report_mismatch("final_result", 16'(want.final_res), 16'(got.final_res));
  endtask

  always @(posedge clk_i) begin : watch
    res_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_byte(in_byte_i, end_of_message_i, xor_bpp_i);
        if (cur_row.typed) pending_beats.push_back(cur_row.want);
        else foreach (byte_beats[i]) pending_beats.push_back(byte_beats[i]);
      end
      if (out_valid_o && !out_stall_i) begin
        got             = '0;
        got.kind        = kind_e'(kind_o);
        got.cache_slot  = cache_slot_o;
        got.hot_x       = hot_x_o;
        got.hot_y       = hot_y_o;
        got.width       = pointer_width_o;
        got.height      = pointer_height_o;
        got.mask_byte   = mask_byte_o;
        got.mask_offset = mask_offset_o;
        got.fail_code   = fail_e'(fail_code_o);
        got.final_res   = final_result_o;
        if (pending_beats.size() == 0) report_mismatch("beat with none pending, kind",
                                                        16'd0, 16'(kind_o));
        else check_beat(pending_beats.pop_front(), got);
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b);
    stim_row_t row;
    row.b     = b;
    row.eom   = 1'b0;
    row.bpp   = 8'($urandom);  // only the first byte of a message is sampled
    row.typed = 1'b0;
    row.want  = '0;
    msg.push_back(row);
  endfunction

  function automatic void push_header(input logic [15:0] cache, x, y, w, h, al, xl,
                                      input logic [7:0] bpp);
    logic [15:0] f [NumHdrFields];
    int unsigned first;
    first = msg.size();
    f = '{cache, x, y, w, h, al, xl};
    foreach (f[i]) begin
      push_byte(f[i][7:0]);
      push_byte(f[i][15:8]);
    end
    msg[first].bpp = bpp;
  endfunction

  function automatic void random_message();
    logic [15:0] w, h, x, y, xl, al;
    logic [7:0] bpp;
    int unsigned sel, total, cut;
    msg.delete();
    sel = $urandom_range(99);
    bpp = BppSet[$urandom_range(6)];
    case ($urandom_range(9))
      0: begin
        w = 16'($urandom_range(96, 88));
        h = 16'($urandom_range(2));
        if (bpp > 8'd8) bpp = 8'd8;
      end
      1: begin
        w = 16'($urandom_range(2));
        h = 16'($urandom_range(96, 88));
        if (bpp > 8'd8) bpp = 8'd8;
      end
      2: begin
        w   = 16'($urandom_range(4));
        h   = 16'($urandom_range(1));
        bpp = 8'($urandom);
      end
      default: begin
        w = 16'($urandom_range(12));
        h = 16'($urandom_range(6));
      end
    endcase
    xl = ($urandom_range(4) == 0) ? 16'd0
                                  : 16'(even_scan(32'(bpp) * 32'(w)) * 32'(h));
    al = ($urandom_range(4) == 0) ? 16'd0 : 16'(even_scan(32'(w)) * 32'(h));
    x  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(32'(w) + 1));
    y  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(32'(h) + 1));
    total = 32'(xl) + 32'(al);
    // correct lengths are always even, so adding one always breaks them
    if (sel < 8) begin
      if ($urandom_range(1)) w = 16'($urandom_range(16'hFFFF, 97));
      else h = 16'($urandom_range(16'hFFFF, 97));
      if ($urandom_range(1)) xl = xl + 16'd1;
    end else if (sel < 16) begin
      xl = xl + 16'($urandom_range(5, 1));
    end else if (sel < 24) begin
      al = al + 16'($urandom_range(5, 1));
      if ($urandom_range(1)) xl = xl + 16'd1;
    end
    push_header(16'($urandom), x, y, w, h, al, xl, bpp);
    if (sel < 24) begin
      repeat ($urandom_range(3)) push_byte(8'($urandom));
    end else if (sel < 30) begin
      cut = $urandom_range(12);
      msg = msg[0:cut];
    end else if (sel < 38 && total > 0) begin
      repeat ($urandom_range(total - 1)) push_byte(8'($urandom));
    end else if (sel < 41) begin
      msg.delete();
      repeat ($urandom_range(17, 1)) push_byte(8'($urandom));
    end else begin
      repeat (total) push_byte(8'($urandom));
      repeat ($urandom_range(2)) push_byte(8'($urandom));
    end
    msg[msg.size() - 1].eom = 1'b1;
  endfunction

  task automatic offer(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i       <= 1'b0;
      in_byte_i        <= 8'($urandom);
      end_of_message_i <= 1'($urandom);
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_byte_i        <= row.b;
    end_of_message_i <= row.eom;
    xor_bpp_i        <= row.bpp;
    cur_row          <= row;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned rand_bytes, ph;
    rand_bytes = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 9;
    stall_pct     = 9;
    // one byte then end of message: short header
    push_byte(8'hA5);
    msg[0].eom   = 1'b1;
    msg[0].typed = 1'b1;
    msg[0].want  = fail_beat(FAIL_SHORT);
    // width just over the limit, then one drained byte
    push_header(16'hFFFF, 16'h0000, 16'h0000, 16'd97, 16'd96, 16'h0000, 16'h0000, 8'hFF);
    msg[14].typed = 1'b1;
    msg[14].want  = fail_beat(FAIL_SIZE);
    push_byte(8'h00);
    msg[15].eom = 1'b1;
    // largest pointer, hot x clamped, no masks, end on the last header byte
    push_header(16'h0000, 16'hFFFF, 16'd95, 16'd96, 16'd96, 16'h0000, 16'h0000, 8'h00);
    msg[29].eom = 1'b1;
    foreach (msg[i]) offer(msg[i]);

    pressure_go = 1'b1;
    while (rand_bytes < RandItems) begin
      ph            = rand_bytes * 4 / RandItems;
      send_idle_pct = SendIdle[ph];
      stall_pct     = RecvStall[ph];
      random_message();
      foreach (msg[i]) offer(msg[i]);
      rand_bytes += msg.size();
    end
    in_valid_i <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
